### rtl/core/swpi_pkg.sv
// ----------------------------------------------------------------------------
// Steering and wheel speed PI control: shared package
// Widths, fixed constants, configuration register indexes, the sequencer state
// type and the control word of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swpi_pkg;

  // Field and register widths
  localparam int GAIN_W     = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int ERROR_W    = 16;
  localparam int SENSOR_W   = 10;
  localparam int RATE_W     = 16;
  localparam int SPEED_W    = 12;
  localparam int DUTY_W     = 14;
  localparam int TGT_W      = 16;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;

  // Datapath widths: multiplier operands, accumulator, correction, wheel error
  localparam int OPA_W  = 22;
  localparam int OPB_W  = 13;
  localparam int ACC_W  = 32;
  localparam int CORR_W = 22;
  localparam int ERR_W  = 13;

  // Fixed constants (Q0.8 gains, duty limits, lost-sensor corrections, sensor thresholds)
  localparam int YAW_GAIN_HIGH   = 31;
  localparam int YAW_GAIN_LOW    = 8;
  localparam int CORR_SHARE      = 51;
  localparam int DUTY_LEFT_MAX   = 8000;
  localparam int DUTY_RIGHT_MAX  = 7000;
  localparam int DUTY_MIN        = -3500;
  localparam int LOST_LEFT_CORR  = -73;
  localparam int LOST_RIGHT_CORR = 74;
  localparam int SENSOR_NEAR     = 15;
  localparam int SENSOR_STRONG   = 45;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEER_P  = 4'd0,
    CFG_STEER_D  = 4'd1,
    CFG_YAW_SLOW = 4'd2,
    CFG_PIT_SLOW = 4'd3,
    CFG_LEFT_KP  = 4'd4,
    CFG_LEFT_KI  = 4'd5,
    CFG_RIGHT_KP = 4'd6,
    CFG_RIGHT_KI = 4'd7
  } cfg_reg_e;

  // Sequencer steps, one per cycle; idle waits for a tick and the push step stalls on a full output register
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_EP,
    ST_MUL_DED,
    ST_MUL_YAWK,
    ST_CORR_SUM,
    ST_MUL_YG,
    ST_MUL_PG,
    ST_MUL_SH,
    ST_TGT_R,
    ST_TGT_L,
    ST_ERR,
    ST_MUL_LKP,
    ST_MUL_LKI,
    ST_DUTY_L,
    ST_CLAMP_L,
    ST_MUL_RKI,
    ST_DUTY_R,
    ST_CLAMP_R,
    ST_PUSH
  } swpi_state_e;

  // First adder operand of the accumulate unit
  typedef enum logic [1:0] {
    A_ZERO,
    A_ACC,
    A_EXT
  } add_sel_e;

  // Control word of the multiply-accumulate unit
  typedef struct packed {
    logic     mul_en;
    add_sel_e a_sel;
    logic     sub;
    logic     acc_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/steer_and_wheel_speed_pi_control.sv
// ----------------------------------------------------------------------------
// Steering and wheel speed PI control
// One control tick forms a steering correction from the line error, the
// sensor levels and the yaw rate, derives both wheel targets and runs an
// incremental PI loop per wheel, all through one shared multiplier.
// ----------------------------------------------------------------------------
//
//  Port group    Dir  Word contents
//  s_axis_*      in   one control tick: errors, sensor levels, rates, speeds
//  m_axis_*      out  one result: duties, targets, stopped flag
//  cfg_*         in   gain register writes, no read-back
//
// The result word is registered at the end of the step sequence, and the next
// tick can be accepted once the sequencer is back in idle. This is set by
// the ten products that go one after another through the single multiplier.
// The input side is ready only in the idle step; a new tick may be taken
// while the last result still waits on the output register.
// A full output register stalls the final step until the word is taken.
// Reset restores the gain defaults and clears the controller history.
// ----------------------------------------------------------------------------
`default_nettype none

module steer_and_wheel_speed_pi_control #(
  parameter int unsigned BASE_SPEED = 150
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input word, from bit 0: line_error[15:0], sensor_left[25:16],
  // sensor_right[35:26], yaw_rate[51:36], pitch_rate[67:52],
  // speed_left[79:68], speed_right[91:80], zero fill[95:92]
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [swpi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // Output word, from bit 0: duty_left[13:0], duty_right[27:14],
  // target_left[43:28], target_right[59:44], stopped[60], zero fill[63:61]
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [swpi_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // Configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [swpi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [swpi_pkg::GAIN_W-1:0]          cfg_data_i
);
  import swpi_pkg::*;

  typedef struct packed {
    logic stopped;
    logic lost_l;
    logic lost_r;
    logic k_hi;
  } swpi_flags_t;

  localparam logic signed [ACC_W-1:0] BASE_Q16 = $signed(ACC_W'(BASE_SPEED << 16));

  // Floor a Q.16 value to Q8.8 and saturate to the target width.
  function automatic logic signed [TGT_W-1:0] sat_target(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] f;
    logic signed [TGT_W-1:0] res;
    f = v >>> 8;
    if ((f[ACC_W-1:TGT_W-1] == '0) || (f[ACC_W-1:TGT_W-1] == '1)) begin
      res = f[TGT_W-1:0];
    end else if (f[ACC_W-1]) begin
      res = {1'b1, {(TGT_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(TGT_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Wheel error: (target - speed * 256) / 256, truncated toward zero.
  function automatic logic signed [ERR_W-1:0] wheel_err(input logic signed [TGT_W-1:0] t,
                                                        input logic signed [SPEED_W-1:0] v);
    logic signed [ERR_W-1:0] f;
    f = ERR_W'(t >>> 8) - ERR_W'(v);
    if (f[ERR_W-1] && (t[7:0] != 8'd0)) begin
      f = f + ERR_W'(1);
    end
    return f;
  endfunction

  // Truncate a Q.8 duty toward zero and clamp it to the wheel limits.
  function automatic logic signed [DUTY_W-1:0] clamp_duty(input logic signed [ACC_W-1:0] v,
                                                          input logic signed [DUTY_W-1:0] hi);
    logic signed [ACC_W-1:0]  fl;
    logic signed [ACC_W-1:0]  hi_w;
    logic signed [ACC_W-1:0]  lo_w;
    logic signed [DUTY_W-1:0] res;
    fl = v >>> 8;
    if (v[ACC_W-1] && (v[7:0] != 8'd0)) begin
      fl = fl + ACC_W'(1);
    end
    hi_w = hi;
    lo_w = ACC_W'(DUTY_MIN);
    if (fl >= hi_w) begin
      res = hi;
    end else if (fl <= lo_w) begin
      res = DUTY_W'(DUTY_MIN);
    end else begin
      res = fl[DUTY_W-1:0];
    end
    return res;
  endfunction

  swpi_state_e state_q, state_d;

  // Gain registers
  logic [GAIN_W-1:0] steer_p_q, steer_d_q, yaw_slow_q, pit_slow_q;
  logic [GAIN_W-1:0] left_kp_q, left_ki_q, right_kp_q, right_ki_q;

  // Controller history
  logic signed [ERROR_W-1:0] prev_line_error_q;
  logic signed [ERR_W-1:0]   prev_err_l_q, prev_err_r_q;
  logic signed [DUTY_W-1:0]  duty_acc_l_q, duty_acc_r_q;

  // Latched tick and working values
  logic signed [ERROR_W-1:0] e_q;
  logic signed [RATE_W-1:0]  yaw_q, pitch_q;
  logic signed [SPEED_W-1:0] vl_q, vr_q;
  swpi_flags_t               flags_q;
  logic signed [CORR_W-1:0]  corr_q;
  logic signed [TGT_W-1:0]   tl_q, tr_q;
  logic signed [ERR_W-1:0]   err_l_q, err_r_q;

  // Output register
  logic                      out_valid_q;
  logic signed [DUTY_W-1:0]  out_dl_q, out_dr_q;
  logic signed [TGT_W-1:0]   out_tl_q, out_tr_q;
  logic                      out_stop_q;

  // Accept-time sensor decode
  logic [SENSOR_W-1:0] sl, sr, sdiff;
  swpi_flags_t         flags_d;

  // Shared unit hookup
  mac_ctrl_t                mac_ctrl;
  logic signed [OPA_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]  ext_val;
  logic signed [ACC_W-1:0]  acc_val;
  logic signed [ACC_W-1:0]  sum_val;
  logic signed [OPA_W-1:0]  yaw_abs, pitch_abs;

  logic in_fire, out_free;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_stop_q, out_tr_q, out_tl_q, out_dr_q, out_dl_q};

  // Sensor conditions of the incoming tick.
  assign sl    = s_axis_tdata[25:16];
  assign sr    = s_axis_tdata[35:26];
  assign sdiff = (sl >= sr) ? (sl - sr) : (sr - sl);

  always_comb begin
    flags_d.stopped = (sl == '0) && (sr == '0);
    flags_d.lost_l  = (sl <= SENSOR_W'(SENSOR_NEAR)) && (sl < sr);
    flags_d.lost_r  = !flags_d.lost_l && (sr <= SENSOR_W'(SENSOR_NEAR)) &&
                      (sl != '0) && (sr < sl);
    flags_d.k_hi    = (sdiff <= SENSOR_W'(SENSOR_NEAR)) &&
                      (sl >= SENSOR_W'(SENSOR_STRONG)) && (sr >= SENSOR_W'(SENSOR_STRONG));
  end

  assign yaw_abs   = yaw_q[RATE_W-1] ? -OPA_W'(yaw_q) : OPA_W'(yaw_q);
  assign pitch_abs = pitch_q[RATE_W-1] ? -OPA_W'(pitch_q) : OPA_W'(pitch_q);

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_MUL_EP;
      ST_MUL_EP:   state_d = ST_MUL_DED;
      ST_MUL_DED:  state_d = ST_MUL_YAWK;
      ST_MUL_YAWK: state_d = ST_CORR_SUM;
      ST_CORR_SUM: state_d = ST_MUL_YG;
      ST_MUL_YG:   state_d = ST_MUL_PG;
      ST_MUL_PG:   state_d = ST_MUL_SH;
      ST_MUL_SH:   state_d = ST_TGT_R;
      ST_TGT_R:    state_d = ST_TGT_L;
      ST_TGT_L:    state_d = ST_ERR;
      ST_ERR:      state_d = ST_MUL_LKP;
      ST_MUL_LKP:  state_d = ST_MUL_LKI;
      ST_MUL_LKI:  state_d = ST_DUTY_L;
      ST_DUTY_L:   state_d = ST_CLAMP_L;
      ST_CLAMP_L:  state_d = ST_MUL_RKI;
      ST_MUL_RKI:  state_d = ST_DUTY_R;
      ST_DUTY_R:   state_d = ST_CLAMP_R;
      ST_CLAMP_R:  state_d = ST_PUSH;
      ST_PUSH:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit control and operand selection for each step.
  always_comb begin
    mac_ctrl = '{mul_en: 1'b0, a_sel: A_ACC, sub: 1'b0, acc_en: 1'b0};
    mul_a    = OPA_W'(e_q);
    mul_b    = $signed({1'b0, steer_p_q});
    ext_val  = BASE_Q16;
    case (state_q)
      ST_MUL_EP: begin
        mac_ctrl.mul_en = 1'b1;
      end
      ST_MUL_DED: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_ZERO, sub: 1'b0, acc_en: 1'b1};
        mul_a    = OPA_W'(e_q) - OPA_W'(prev_line_error_q);
        mul_b    = $signed({1'b0, steer_d_q});
      end
      ST_MUL_YAWK: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_ACC, sub: 1'b0, acc_en: 1'b1};
        mul_a    = OPA_W'(yaw_q);
        mul_b    = flags_q.k_hi ? OPB_W'(YAW_GAIN_HIGH) : OPB_W'(YAW_GAIN_LOW);
      end
      ST_CORR_SUM: begin
        mac_ctrl.acc_en = 1'b1;
      end
      ST_MUL_YG: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = yaw_abs;
        mul_b           = $signed({1'b0, yaw_slow_q});
      end
      ST_MUL_PG: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_EXT, sub: 1'b1, acc_en: 1'b1};
        mul_a    = pitch_abs;
        mul_b    = $signed({1'b0, pit_slow_q});
        ext_val  = BASE_Q16;
      end
      ST_MUL_SH: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_ACC, sub: 1'b1, acc_en: 1'b1};
        mul_a    = corr_q;
        mul_b    = OPB_W'(CORR_SHARE);
      end
      ST_TGT_R: begin
        mac_ctrl.sub = 1'b1;
      end
      ST_MUL_LKP: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = OPA_W'(err_l_q) - OPA_W'(prev_err_l_q);
        mul_b           = $signed({1'b0, left_kp_q});
      end
      ST_MUL_LKI: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_EXT, sub: 1'b0, acc_en: 1'b1};
        mul_a    = OPA_W'(err_l_q);
        mul_b    = $signed({1'b0, left_ki_q});
        ext_val  = ACC_W'(duty_acc_l_q) <<< 8;
      end
      ST_DUTY_L: begin
        mac_ctrl.acc_en = 1'b1;
      end
      ST_CLAMP_L: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = OPA_W'(err_r_q) - OPA_W'(prev_err_r_q);
        mul_b           = $signed({1'b0, right_kp_q});
      end
      ST_MUL_RKI: begin
        mac_ctrl = '{mul_en: 1'b1, a_sel: A_EXT, sub: 1'b0, acc_en: 1'b1};
        mul_a    = OPA_W'(err_r_q);
        mul_b    = $signed({1'b0, right_ki_q});
        ext_val  = ACC_W'(duty_acc_r_q) <<< 8;
      end
      ST_DUTY_R: begin
        mac_ctrl.acc_en = 1'b1;
      end
      default: begin
        mac_ctrl = '{mul_en: 1'b0, a_sel: A_ACC, sub: 1'b0, acc_en: 1'b0};
      end
    endcase
  end

  swpi_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .ext_i   (ext_val),
    .acc_o   (acc_val),
    .sum_o   (sum_val)
  );

  // Control state, gains and controller history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      out_valid_q       <= 1'b0;
      steer_p_q         <= GAIN_W'(493);
      steer_d_q         <= GAIN_W'(73);
      yaw_slow_q        <= GAIN_W'(33);
      pit_slow_q        <= GAIN_W'(64);
      left_kp_q         <= GAIN_W'(512);
      left_ki_q         <= GAIN_W'(566);
      right_kp_q        <= GAIN_W'(714);
      right_ki_q        <= GAIN_W'(538);
      prev_line_error_q <= '0;
      prev_err_l_q      <= '0;
      prev_err_r_q      <= '0;
      duty_acc_l_q      <= '0;
      duty_acc_r_q      <= '0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEER_P:  steer_p_q  <= cfg_data_i;
          CFG_STEER_D:  steer_d_q  <= cfg_data_i;
          CFG_YAW_SLOW: yaw_slow_q <= cfg_data_i;
          CFG_PIT_SLOW: pit_slow_q <= cfg_data_i;
          CFG_LEFT_KP:  left_kp_q  <= cfg_data_i;
          CFG_LEFT_KI:  left_ki_q  <= cfg_data_i;
          CFG_RIGHT_KP: right_kp_q <= cfg_data_i;
          CFG_RIGHT_KI: right_ki_q <= cfg_data_i;
          default: ;
        endcase
      end

      // The line error history moves only on a normal PD correction.
      if (state_q == ST_MUL_YG &&
          !(flags_q.stopped || flags_q.lost_l || flags_q.lost_r)) begin
        prev_line_error_q <= e_q;
      end

      if (state_q == ST_CLAMP_L) begin
        prev_err_l_q <= err_l_q;
        duty_acc_l_q <= clamp_duty(acc_val, DUTY_W'(DUTY_LEFT_MAX));
      end

      if (state_q == ST_CLAMP_R) begin
        prev_err_r_q <= err_r_q;
        duty_acc_r_q <= clamp_duty(acc_val, DUTY_W'(DUTY_RIGHT_MAX));
      end
    end
  end

  // Working values and the result word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q     <= s_axis_tdata[15:0];
      yaw_q   <= s_axis_tdata[51:36];
      pitch_q <= s_axis_tdata[67:52];
      vl_q    <= s_axis_tdata[79:68];
      vr_q    <= s_axis_tdata[91:80];
      flags_q <= flags_d;
    end

    // Correction: fixed value on a lost sensor, else the floored sum of the PD and yaw terms.
    if (state_q == ST_MUL_YG) begin
      if (flags_q.lost_l) begin
        corr_q <= CORR_W'(LOST_LEFT_CORR * 256);
      end else if (flags_q.lost_r) begin
        corr_q <= CORR_W'(LOST_RIGHT_CORR * 256);
      end else begin
        corr_q <= acc_val[CORR_W+7:8];
      end
    end

    if (state_q == ST_TGT_R) begin
      tr_q <= flags_q.stopped ? '0 : sat_target(sum_val);
    end
    if (state_q == ST_TGT_L) begin
      tl_q <= flags_q.stopped ? '0 : sat_target(sum_val);
    end

    if (state_q == ST_ERR) begin
      err_l_q <= wheel_err(tl_q, vl_q);
      err_r_q <= wheel_err(tr_q, vr_q);
    end

    if (state_q == ST_PUSH && out_free) begin
      out_dl_q   <= duty_acc_l_q;
      out_dr_q   <= duty_acc_r_q;
      out_tl_q   <= tl_q;
      out_tr_q   <= tr_q;
      out_stop_q <= flags_q.stopped;
    end
  end

`ifndef NO_ASSERTIONS
  // Left duty stays within its clamp limits.
  a_duty_l_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dl_q >= DUTY_W'(DUTY_MIN)) && (out_dl_q <= DUTY_W'(DUTY_LEFT_MAX)))
    else $error("left duty outside its limits");

  // Right duty stays within its clamp limits.
  a_duty_r_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dr_q >= DUTY_W'(DUTY_MIN)) && (out_dr_q <= DUTY_W'(DUTY_RIGHT_MAX)))
    else $error("right duty outside its limits");

  // A stopped tick reports zero targets.
  a_stop_targets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stop_q) |-> (out_tl_q == '0) && (out_tr_q == '0))
    else $error("stopped result with nonzero target");

  // Lost or stopped ticks keep the line error history.
  a_prev_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_YG && (flags_q.stopped || flags_q.lost_l || flags_q.lost_r))
      |=> $stable(prev_line_error_q))
    else $error("line error history moved on a lost or stopped tick");

  // An accepted tick starts the sequence at once.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL_EP))
    else $error("accepted tick did not start the sequence");
`endif

endmodule

`default_nettype wire

### rtl/core/swpi_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// One signed multiplier with a registered product, followed by one adder
// that adds or subtracts the product to the accumulator, an external value
// or zero.
// ----------------------------------------------------------------------------
`default_nettype none

module swpi_mac (
  input  wire logic                                   clk_i,
  input  wire swpi_pkg::mac_ctrl_t                    ctrl_i,
  input  wire logic signed [swpi_pkg::OPA_W-1:0]      mul_a_i,
  input  wire logic signed [swpi_pkg::OPB_W-1:0]      mul_b_i,
  input  wire logic signed [swpi_pkg::ACC_W-1:0]      ext_i,
  output logic signed [swpi_pkg::ACC_W-1:0]           acc_o,
  output logic signed [swpi_pkg::ACC_W-1:0]           sum_o
);
  import swpi_pkg::*;

  logic signed [OPA_W+OPB_W-1:0] mul_full;
  logic signed [ACC_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [ACC_W-1:0]       add_a;

  // Full product; every product used here fits the accumulator width.
  assign mul_full = mul_a_i * mul_b_i;

  // Adder operand selection and the add or subtract of the product.
  always_comb begin
    case (ctrl_i.a_sel)
      A_ZERO:  add_a = '0;
      A_ACC:   add_a = acc_q;
      A_EXT:   add_a = ext_i;
      default: add_a = '0;
    endcase
  end

  assign sum_o = ctrl_i.sub ? (add_a - prod_q) : (add_a + prod_q);
  assign acc_o = acc_q;

  // Product and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_full[ACC_W-1:0];
    end
    if (ctrl_i.acc_en) begin
      acc_q <= sum_o;
    end
  end

endmodule

`default_nettype wire
